// ===== sv/mbss_pkg.sv =====
// Shared constants, types and helpers for the masked byte signature scanner.
package mbss_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int IDX_BITS     = $clog2(WINDOW_DEPTH);
  localparam int LEN_BITS     = 5;
  localparam int OFFSET_BITS  = 32;
  localparam int ADDR_BITS    = 64;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

  localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_LO    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_HI    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CARE_MASK = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_LEN   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REVERSE   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BASE      = 3'd5;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic  compare;
    byte_t pat;
  } cell_ctl_t;

  function automatic logic [IDX_BITS-1:0] used_len_m1(input logic [LEN_BITS-1:0] len);
    logic [IDX_BITS-1:0] r;
    if (len == '0) begin
      r = '0;
    end else if (len > LEN_BITS'(WINDOW_DEPTH)) begin
      r = IDX_BITS'(WINDOW_DEPTH - 1);
    end else begin
      r = IDX_BITS'(len - LEN_BITS'(1));
    end
    return r;
  endfunction

endpackage

// ===== sv/masked_byte_signature_scanner.sv =====
// Top level: config registers, range bookkeeping and result register.
// Takes one byte per cycle while the output is not stalled; a byte may then follow in every cycle.
// The result is registered and appears in the cycle after the byte marked end of range is taken.
// The input stays ready while a result waits, unless the output is stalled.
// Reset restores register defaults, clears match state and empties the output.
module masked_byte_signature_scanner import mbss_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,   // [7:0] data_byte
  input  logic                    s_axis_tlast,   // end_of_range
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [ADDR_BITS-1:0]    m_axis_tdata,   // [63:0] match_address
  output logic                    m_axis_tuser,   // found
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ADDR_BITS-1:0]    cfg_data
);

  logic [ADDR_BITS-1:0]    pat_lo;
  logic [ADDR_BITS-1:0]    pat_hi;
  logic [WINDOW_DEPTH-1:0] care_mask;
  logic [LEN_BITS-1:0]     pat_len;
  logic                    reverse;
  logic [ADDR_BITS-1:0]    range_base;

  logic [OFFSET_BITS-1:0]  byte_count;
  logic                    have_match;
  logic [OFFSET_BITS-1:0]  match_offset;

  logic                    out_valid;
  logic                    out_found;
  logic [ADDR_BITS-1:0]    out_addr;

  logic                    accept;
  logic                    window_hit;
  logic [IDX_BITS-1:0]     len_m1;
  logic                    count_live;
  logic                    take;
  logic [OFFSET_BITS-1:0]  start;
  logic                    found_next;
  logic [OFFSET_BITS-1:0]  offset_next;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign len_m1        = used_len_m1(pat_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_lo     <= '0;
      pat_hi     <= '0;
      care_mask  <= '0;
      pat_len    <= LEN_BITS'(1);
      reverse    <= 1'b0;
      range_base <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PAT_LO:    pat_lo     <= cfg_data;
        CFG_PAT_HI:    pat_hi     <= cfg_data;
        CFG_CARE_MASK: care_mask  <= cfg_data[WINDOW_DEPTH-1:0];
        CFG_PAT_LEN:   pat_len    <= cfg_data[LEN_BITS-1:0];
        CFG_REVERSE:   reverse    <= cfg_data[0];
        CFG_BASE:      range_base <= cfg_data;
        default: ;
      endcase
    end
  end

  mbss_chain u_chain (
    .clk       (clk),
    .shift     (accept),
    .din       (s_axis_tdata),
    .pattern   ({pat_hi, pat_lo}),
    .care      (care_mask),
    .len_m1    (len_m1),
    .window_hit(window_hit)
  );

  always_comb begin
    count_live  = (byte_count != OFFSET_MAX);
    start       = byte_count - OFFSET_BITS'(len_m1);
    take        = count_live && (byte_count >= OFFSET_BITS'(len_m1)) && window_hit
                  && (reverse || !have_match);
    found_next  = have_match || take;
    offset_next = take ? start : match_offset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      have_match   <= 1'b0;
      match_offset <= '0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        byte_count   <= '0;
        have_match   <= 1'b0;
        match_offset <= '0;
      end else begin
        if (take) begin
          have_match   <= 1'b1;
          match_offset <= start;
        end
        if (count_live) begin
          byte_count <= byte_count + OFFSET_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && s_axis_tlast) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_axis_tlast) begin
      out_found <= found_next;
      out_addr  <= found_next ? range_base + ADDR_BITS'(offset_next) : '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_found;
  assign m_axis_tdata  = out_addr;

  a_no_addr_without_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("address nonzero on a result without a match");

  a_result_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
    else $error("result raised without an end-of-range request");

  a_range_cleared: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> byte_count == '0 && !have_match)
    else $error("range state not cleared after end of range");

  a_offset_in_range: assert property (@(posedge clk) disable iff (rst)
    have_match |-> match_offset < byte_count)
    else $error("held match offset beyond bytes received");

endmodule

// ===== sv/mbss_cell.sv =====
// One window cell: holds one byte and compares the byte shifting into it.
module mbss_cell import mbss_pkg::*; (
  input  logic      clk,
  input  logic      shift,
  input  byte_t     din,
  input  cell_ctl_t ctl,
  output byte_t     dout,
  output logic      hit
);

  byte_t held;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= din;
    end
  end

  assign dout = held;
  assign hit  = !ctl.compare || (din == ctl.pat);

endmodule

// ===== sv/mbss_chain.sv =====
// Row of window cells with per-cell pattern alignment and the combined match.
module mbss_chain import mbss_pkg::*; (
  input  logic                      clk,
  input  logic                      shift,
  input  byte_t                     din,
  input  logic [2*ADDR_BITS-1:0]    pattern,
  input  logic [WINDOW_DEPTH-1:0]   care,
  input  logic [IDX_BITS-1:0]       len_m1,
  output logic                      window_hit
);

  byte_t [WINDOW_DEPTH-1:0]     cell_q;
  logic  [WINDOW_DEPTH-1:0]     cell_hit;
  cell_ctl_t [WINDOW_DEPTH-1:0] ctl;

  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    logic [IDX_BITS-1:0] pidx;
    byte_t               cin;

    assign pidx = len_m1 - IDX_BITS'(k);
    assign ctl[k].compare = (IDX_BITS'(k) <= len_m1) && care[pidx];
    assign ctl[k].pat     = pattern[pidx*8 +: 8];

    if (k == 0) begin : g_head
      assign cin = din;
    end else begin : g_body
      assign cin = cell_q[k-1];
    end

    mbss_cell u_cell (
      .clk  (clk),
      .shift(shift),
      .din  (cin),
      .ctl  (ctl[k]),
      .dout (cell_q[k]),
      .hit  (cell_hit[k])
    );
  end

  assign window_hit = &cell_hit;

endmodule

// ===== tb/tb_masked_byte_signature_scanner.sv =====
// Testbench for the masked byte signature scanner: directed table, then random ranges.
module tb_masked_byte_signature_scanner;
  timeunit 1ns;
  timeprecision 1ps;
  import mbss_pkg::*;

  typedef struct packed {
    logic                 found;
    logic [ADDR_BITS-1:0] addr;
  } scan_result_t;

  typedef struct {
    bit                       is_cfg;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [ADDR_BITS-1:0]     val;
    byte_t                    d;
    logic                     last_in;
    bit                       typed;
    scan_result_t             want;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_valid = 1'b0;
  logic                    s_ready;
  byte_t                   s_data = '0;
  logic                    s_last = 1'b0;
  logic                    m_valid;
  logic                    m_ready = 1'b0;
  logic [ADDR_BITS-1:0]    m_data;
  logic                    m_user;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
  logic [ADDR_BITS-1:0]    cfg_wdata = '0;

  // register copies and per-range scan state
  logic [127:0]           sig_bytes = '0;
  logic [15:0]            care = '0;
  logic [LEN_BITS-1:0]    sig_len = LEN_BITS'(1);
  logic                   rev = 1'b0;
  logic [ADDR_BITS-1:0]   base = '0;
  byte_t                  win [WINDOW_DEPTH] = '{default: 8'h00};
  logic [OFFSET_BITS-1:0] seen_count = '0;
  logic                   held = 1'b0;
  logic [OFFSET_BITS-1:0] held_off = '0;

  scan_result_t expected_results[$];
  plan_row_t    plan[$];
  scan_result_t want;
  int mismatches = 0;
  int items_sent = 0;
  int burst_left = 0;
  int rx_cycle = 0;

  masked_byte_signature_scanner dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_idx),
    .cfg_data      (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int eff_len();
    if (sig_len == '0) return 1;
    if (sig_len > LEN_BITS'(WINDOW_DEPTH)) return WINDOW_DEPTH;
    return int'(sig_len);
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [ADDR_BITS-1:0] val);
    case (idx)
      CFG_PAT_LO:    sig_bytes[63:0] = val;
      CFG_PAT_HI:    sig_bytes[127:64] = val;
      CFG_CARE_MASK: care = val[15:0];
      CFG_PAT_LEN:   sig_len = val[LEN_BITS-1:0];
      CFG_REVERSE:   rev = val[0];
      CFG_BASE:      base = val;
      default: ;
    endcase
  endfunction

  function automatic bit scan_byte(input byte_t d, input logic last_in,
                                   output scan_result_t res);
    int n;
    bit hit;
    n = eff_len();
    res = '0;
    for (int k = WINDOW_DEPTH - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = d;
    if (seen_count != OFFSET_MAX) begin
      if ({1'b0, seen_count} + 33'd1 >= 33'(n)) begin
        hit = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (care[i] && win[n-1-i] != sig_bytes[i*8 +: 8]) hit = 1'b0;
        end
        if (hit && (rev || !held)) begin
          held = 1'b1;
          held_off = seen_count + OFFSET_BITS'(1) - OFFSET_BITS'(n);
        end
      end
      seen_count++;
    end
    if (!last_in) return 1'b0;
    res.found = held;
    res.addr = held ? base + ADDR_BITS'(held_off) : '0;
    win = '{default: 8'h00};
    seen_count = '0;
    held = 1'b0;
    held_off = '0;
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input logic [ADDR_BITS-1:0] exp_v,
                               input logic [ADDR_BITS-1:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: mismatch on %s: expected %h, got %h", $time, what, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    if (!rst && m_valid && m_ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result", '0, m_data);
      end else begin
        want = expected_results.pop_front();
        if (want.found !== m_user) note_mismatch("found", ADDR_BITS'(want.found),
                                                 ADDR_BITS'(m_user));
        if (want.addr !== m_data) note_mismatch("match_address", want.addr, m_data);
      end
    end
  end

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 256) % 4)
      0: m_ready <= 1'b1;
      1: m_ready <= ($urandom_range(0, 1) == 1);
      2: m_ready <= (rx_cycle % 5 == 0);
      default: m_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_byte(input byte_t d, input logic last_in, input bit typed,
                           input scan_result_t typed_res);
    int gap;
    scan_result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data <= d;
    s_last <= last_in;
    do @(posedge clk); while (!s_ready);
    items_sent++;
    if (scan_byte(d, last_in, res)) expected_results.push_back(typed ? typed_res : res);
  endtask

  // drop valid, wait out pending results and any trailing work
  task automatic drain();
    s_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [ADDR_BITS-1:0] val, input bit more);
    cfg_valid <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    if (!more) cfg_valid <= 1'b0;
    apply_cfg(idx, val);
  endtask

  function automatic void plan_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                   input logic [ADDR_BITS-1:0] val);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    plan.push_back(r);
  endfunction

  function automatic void plan_byte(input byte_t d);
    plan_row_t r;
    r = '{default: '0};
    r.d = d;
    plan.push_back(r);
  endfunction

  function automatic void plan_end(input byte_t d, input bit typed, input logic found,
                                   input logic [ADDR_BITS-1:0] addr);
    plan_row_t r;
    r = '{default: '0};
    r.d = d;
    r.last_in = 1'b1;
    r.typed = typed;
    r.want.found = found;
    r.want.addr = addr;
    plan.push_back(r);
  endfunction

  task automatic random_setup();
    logic [ADDR_BITS-1:0] len_v, care_v, base_v, rev_v;
    len_v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: len_v[4:0] = 5'd0;
      1: len_v[4:0] = 5'd1;
      2: len_v[4:0] = 5'd16;
      3: len_v[4:0] = 5'($urandom_range(17, 31));
      default: len_v[4:0] = 5'($urandom_range(2, 10));
    endcase
    care_v = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: care_v[15:0] = 16'h0000;
      1: care_v[15:0] = 16'hFFFF;
      default: ;
    endcase
    case ($urandom_range(0, 4))
      0: base_v = '0;
      1: base_v = '1;
      2: base_v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 300));
      default: base_v = {$urandom, $urandom};
    endcase
    rev_v = {$urandom, $urandom};
    drain();
    write_reg(CFG_PAT_LO, {$urandom, $urandom}, 1'b1);
    write_reg(CFG_PAT_HI, {$urandom, $urandom}, 1'b1);
    write_reg(CFG_CARE_MASK, care_v, 1'b1);
    write_reg(CFG_PAT_LEN, len_v, 1'b1);
    write_reg(CFG_REVERSE, rev_v, 1'b1);
    write_reg(CFG_BASE, base_v, 1'b0);
  endtask

  task automatic random_range();
    int n, span, bias, plants, s, j;
    byte_t stream[];
    n = eff_len();
    span = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 250)
                                         : $urandom_range(1, n + 20);
    bias = $urandom_range(0, 2);
    stream = new[span];
    foreach (stream[i]) begin
      if (bias == 0 || $urandom_range(0, 1) == 0) stream[i] = byte_t'($urandom);
      else stream[i] = sig_bytes[$urandom_range(0, n - 1) * 8 +: 8];
    end
    plants = (span >= n) ? $urandom_range(0, 3) : 0;
    for (int p = 0; p < plants; p++) begin
      s = $urandom_range(0, span - n);
      for (int i = 0; i < n; i++)
        stream[s+i] = care[i] ? sig_bytes[i*8 +: 8] : byte_t'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        j = $urandom_range(0, n - 1);
        stream[s+j] ^= byte_t'(1 << $urandom_range(0, 7));
      end
    end
    foreach (stream[i]) send_byte(stream[i], i == span - 1, 1'b0, '0);
  endtask

  initial begin
    int random_target;
    plan_end(8'h55, 1'b1, 1'b1, 64'h0);
    plan_reg(CFG_PAT_LO, 64'hAB);
    plan_reg(CFG_CARE_MASK, 64'h1);
    plan_reg(CFG_BASE, '1);
    plan_byte(8'h00);
    plan_byte(8'hAB);
    plan_end(8'hAB, 1'b1, 1'b1, 64'h0);
    plan_reg(CFG_REVERSE, 64'h1);
    plan_byte(8'hAB);
    plan_byte(8'h00);
    plan_byte(8'hAB);
    plan_end(8'hFF, 1'b1, 1'b1, 64'h1);
    plan_reg(CFG_PAT_LEN, 64'h0);
    plan_end(8'hAB, 1'b1, 1'b1, '1);
    plan_reg(CFG_PAT_LO, 64'h0706_0504_0302_0100);
    plan_reg(CFG_PAT_HI, 64'h0F0E_0D0C_0B0A_0908);
    plan_reg(CFG_CARE_MASK, 64'hFFFF);
    plan_reg(CFG_PAT_LEN, '1);
    plan_reg(CFG_REVERSE, 64'h0);
    plan_reg(CFG_BASE, 64'h0);
    plan_byte(8'h00);
    plan_byte(8'h01);
    plan_end(8'h02, 1'b1, 1'b0, 64'h0);
    plan_reg(CFG_PAT_LO, 64'h5A5A_5A5A_5A33_7711);
    plan_reg(CFG_CARE_MASK, 64'hFFFF_FFFF_FFFF_FFFD);
    plan_reg(CFG_PAT_LEN, 64'h3);
    plan_reg(CFG_BASE, 64'h8000_0000_0000_0000);
    plan_byte(8'h11);
    plan_byte(8'h99);
    plan_byte(8'h33);
    plan_byte(8'h11);
    plan_byte(8'h00);
    plan_end(8'h33, 1'b1, 1'b1, 64'h8000_0000_0000_0000);
    plan_reg(CFG_REVERSE, '1);
    plan_byte(8'h11);
    plan_byte(8'h00);
    plan_byte(8'h33);
    plan_byte(8'h11);
    plan_byte(8'hAB);
    plan_end(8'h33, 1'b0, 1'b0, 64'h0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        if (r == 0 || !plan[r-1].is_cfg) drain();
        write_reg(plan[r].idx, plan[r].val, r + 1 < plan.size() && plan[r+1].is_cfg);
      end else begin
        send_byte(plan[r].d, plan[r].last_in, plan[r].typed, plan[r].want);
      end
    end

    random_target = items_sent + 1350;
    while (items_sent < random_target) begin
      random_setup();
      repeat ($urandom_range(2, 6)) random_range();
    end

    drain();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
